@@ hw/rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Field widths, status and mode codes, sequencer states and word sizing.
// ----------------------------------------------------------------------------
package bba_pkg;

  // defaults of the top level parameters
  localparam int SECTIONS_DEF = 2;
  localparam int BLOCKS_DEF   = 1024;

  // fixed field widths
  localparam int FRAME_W  = 20;
  localparam int BLK_W    = 11;
  localparam int TOTAL_W  = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 32;

  // input item kind
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // low bit of a register index: base or block count
  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_BLOCKS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FREE   = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } bba_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_SEL,
    ST_SCAN,
    ST_FREE_SEL,
    ST_FREE_WR,
    ST_RESP
  } bba_state_e;

  // bitmap word width: 32 bits, or 8 for very small sections
  function automatic int bba_word_width(input int blocks);
    return (blocks >= 32) ? 32 : 8;
  endfunction

endpackage

@@ hw/rtl/bba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bba_word_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_word_search: clear-bit search over one bitmap word
// Masks the word to the live index window and finds the lowest clear bit.
// ----------------------------------------------------------------------------
module bba_word_search
  import bba_pkg::*;
#(
  parameter int WORD_W = 32,
  parameter int WPW    = 5,
  localparam int WB    = $clog2(WORD_W)
) (
  input  logic [WORD_W-1:0] word_i,
  input  logic [WPW-1:0]    wptr_i,
  input  logic [WPW-1:0]    start_w_i,
  input  logic [WB-1:0]     start_b_i,
  input  logic [WPW-1:0]    last_w_i,
  input  logic [WB-1:0]     last_b_i,
  input  logic              wrap_i,
  output logic              found_o,
  output logic [WB-1:0]     pos_o
);

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  logic [WORD_W-1:0] upper_mask;
  logic [WORD_W-1:0] lower_mask;
  logic [WORD_W-1:0] cand;

  // bits at or below the last block of the section
  assign upper_mask = (wptr_i == last_w_i) ?
                      (ALL_ONES >> (WB'(WORD_W - 1) - last_b_i)) : ALL_ONES;

  // first pass: from the cursor up; wrap pass: below the cursor
  always_comb begin
    lower_mask = ALL_ONES;
    if (wptr_i == start_w_i) begin
      lower_mask = wrap_i ? ~(ALL_ONES << start_b_i) : (ALL_ONES << start_b_i);
    end
  end

  assign cand    = ~word_i & upper_mask & lower_mask;
  assign found_o = |cand;

  // lowest candidate wins
  always_comb begin
    pos_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pos_o = WB'(i);
      end
    end
  end

endmodule

@@ hw/rtl/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit: next-fit bitmap block allocator
// Allocates and frees fixed-size blocks over configured sections.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser[0] = mode (0 allocate, 1 free), tdata[19:0] = frame.
//   Output stream: tuser[1:0] = status, tdata = {total_free, granted_frame}.
//   APB port: per section a base frame register and a block count register;
//   writing a block count empties that section. Write only while idle.
// Timing:
//   One word in flight; a new word is taken while the last result waits.
//   Allocation: a selection step per section visited and a scan step per
//   bitmap word read (32 blocks a word, or 8 below 32 blocks a section; the
//   start word is read again on the wrap). Free: a selection step per section
//   checked up to the hit and then a bitmap write, or every section on a miss.
//   Each item then passes the response state; the bitmap RAM read port and
//   the single word search set the pace.
// Reset:
//   Control and config registers zero: no section has blocks, so nothing
//   can be allocated until a block count is written. Bitmap needs no clearing.
// Stall:
//   A held result blocks completion of the next item only; the sequencer
//   waits with its result until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int SECTIONS           = SECTIONS_DEF,
  parameter int BLOCKS_PER_SECTION = BLOCKS_DEF,
  localparam int RI_W              = (SECTIONS > 1) ? $clog2(2 * SECTIONS) : 1,
  localparam int PA_W              = RI_W + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input words
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // [19:0] frame_number
  input  logic [0:0]       s_axis_tuser,   // [0] mode
  // result words
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [19:0] granted_frame, [32:20] total_free
  output logic [1:0]       m_axis_tuser,   // [1:0] status
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [PA_W-1:0]  paddr,
  input  logic [CFG_W-1:0] pwdata,
  output logic [CFG_W-1:0] prdata,
  output logic             pready
);

  localparam int WORD_W = bba_word_width(BLOCKS_PER_SECTION);
  localparam int WB     = $clog2(WORD_W);
  localparam int WPS    = (BLOCKS_PER_SECTION + WORD_W - 1) / WORD_W;
  localparam int WPW    = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int IDX_W  = WPW + WB;
  localparam int NWORDS = SECTIONS * WPS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int SUM_W  = TOTAL_W + 2;
  localparam logic [BLK_W-1:0] BLK_LIM =
    (BLOCKS_PER_SECTION > 2047) ? '1 : BLK_W'(BLOCKS_PER_SECTION);

  // word address of a section's bitmap word
  function automatic logic [AW-1:0] word_addr(input logic [SEC_W-1:0] sec,
                                               input logic [WPW-1:0] w);
    return AW'(AW'(sec) * AW'(WPS)) + AW'(w);
  endfunction

  // configuration and allocator state
  logic [FRAME_W-1:0] base_q   [SECTIONS];
  logic [BLK_W-1:0]   blocks_q [SECTIONS];
  logic [BLK_W-1:0]   free_q   [SECTIONS];
  logic [BLK_W-1:0]   cursor_q [SECTIONS];
  logic [TOTAL_W-1:0] total_q;
  logic               word_vld_q [NWORDS];

  // sequencer
  bba_state_e       state_q, state_d;
  logic [SEC_W-1:0] sec_q;
  logic [WPW-1:0]   wptr_q;
  logic             wrap_q;
  logic [IDX_W-1:0] start_q;
  logic [WB-1:0]    bit_q;
  logic             rd_vld_q;
  logic [FRAME_W-1:0] frame_q;
  bba_status_e        res_status_q;
  logic [FRAME_W-1:0] res_grant_q;

  // output register
  logic               m_valid_q;
  bba_status_e        out_status_q;
  logic [FRAME_W-1:0] out_grant_q;
  logic [TOTAL_W-1:0] out_total_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, rd_data;

  // current section view
  logic [BLK_W-1:0]   cur_n, cur_free, cur_cursor;
  logic [FRAME_W-1:0] cur_base;
  logic               last_sec, sec_usable, free_hit;
  logic [IDX_W-1:0]   alloc_start, nlast, free_off, found_idx;
  logic [FRAME_W-1:0] frame_diff;
  logic               srch_found;
  logic [WB-1:0]      srch_pos;
  logic               at_end_first, at_end_wrap;

  // sequencer decisions
  logic scan_next, scan_wrap, sec_fail, accept, resp_load;

  // register port decode
  logic               cfg_we;
  logic [RI_W-1:0]    cfg_idx;
  logic               cfg_idx_ok;
  logic [SEC_W-1:0]   cfg_sec;
  logic [BLK_W-1:0]   cfg_blocks;
  logic [SUM_W-1:0]   cfg_sum;
  logic [TOTAL_W-1:0] cfg_total;

  assign cur_n      = blocks_q[sec_q];
  assign cur_free   = free_q[sec_q];
  assign cur_cursor = cursor_q[sec_q];
  assign cur_base   = base_q[sec_q];
  assign last_sec   = (sec_q == SEC_W'(SECTIONS - 1));
  assign sec_usable = (cur_n != '0) && (cur_free != '0);

  // next-fit start; a stale cursor restarts at index zero
  assign alloc_start = (cur_cursor >= cur_n) ? '0 : IDX_W'(cur_cursor);
  assign nlast       = IDX_W'(cur_n - BLK_W'(1));

  // free range check on the current section
  assign free_hit   = (frame_q >= cur_base) &&
                      ({1'b0, frame_q} < ({1'b0, cur_base} + (FRAME_W + 1)'(cur_n)));
  assign frame_diff = frame_q - cur_base;
  assign free_off   = IDX_W'(frame_diff);

  // words never written since the section was set up read as clear
  assign rd_data = rd_vld_q ? ram_rdata : '0;

  bba_word_search #(
    .WORD_W (WORD_W),
    .WPW    (WPW)
  ) u_search (
    .word_i    (rd_data),
    .wptr_i    (wptr_q),
    .start_w_i (start_q[IDX_W-1:WB]),
    .start_b_i (start_q[WB-1:0]),
    .last_w_i  (nlast[IDX_W-1:WB]),
    .last_b_i  (nlast[WB-1:0]),
    .wrap_i    (wrap_q),
    .found_o   (srch_found),
    .pos_o     (srch_pos)
  );

  assign found_idx    = {wptr_q, srch_pos};
  assign at_end_first = !wrap_q && (wptr_q == nlast[IDX_W-1:WB]);
  assign at_end_wrap  = wrap_q && (wptr_q == start_q[IDX_W-1:WB]);

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign resp_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

  // next state, RAM control and sequencer decisions
  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    scan_next = 1'b0;
    scan_wrap = 1'b0;
    sec_fail  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser[0] == MODE_FREE) ? ST_FREE_SEL : ST_ALLOC_SEL;
        end
      end
      ST_ALLOC_SEL: begin
        if (sec_usable) begin
          ram_re    = 1'b1;
          ram_raddr = word_addr(sec_q, alloc_start[IDX_W-1:WB]);
          state_d   = ST_SCAN;
        end else if (last_sec) begin
          state_d = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (srch_found) begin
          ram_we    = 1'b1;
          ram_waddr = word_addr(sec_q, wptr_q);
          ram_wdata = rd_data | (WORD_W'(1) << srch_pos);
          state_d   = ST_RESP;
        end else if ((!wrap_q && !at_end_first) || (wrap_q && !at_end_wrap)) begin
          scan_next = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = word_addr(sec_q, wptr_q + WPW'(1));
        end else if (!wrap_q && (start_q != '0)) begin
          scan_wrap = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = word_addr(sec_q, '0);
        end else begin
          sec_fail = 1'b1;
          state_d  = last_sec ? ST_RESP : ST_ALLOC_SEL;
        end
      end
      ST_FREE_SEL: begin
        if (free_hit) begin
          ram_re    = 1'b1;
          ram_raddr = word_addr(sec_q, free_off[IDX_W-1:WB]);
          state_d   = ST_FREE_WR;
        end else if (last_sec) begin
          state_d = ST_RESP;
        end
      end
      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = word_addr(sec_q, wptr_q);
        ram_wdata = rd_data & ~(WORD_W'(1) << bit_q);
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // register port decode and block count reload sum
  assign cfg_we     = psel && penable && pwrite && pready;
  assign cfg_idx    = paddr[PA_W-1:2];
  assign cfg_idx_ok = (32'(cfg_idx) < 32'(2 * SECTIONS));
  assign cfg_sec    = SEC_W'(cfg_idx >> 1);
  assign cfg_blocks = (pwdata[BLK_W-1:0] > BLK_LIM) ? BLK_LIM : pwdata[BLK_W-1:0];

  always_comb begin
    cfg_sum = '0;
    for (int s = 0; s < SECTIONS; s++) begin
      cfg_sum = cfg_sum + SUM_W'((SEC_W'(s) == cfg_sec) ? cfg_blocks : free_q[s]);
    end
  end

  assign cfg_total = (cfg_sum > SUM_W'({TOTAL_W{1'b1}})) ? '1 : TOTAL_W'(cfg_sum);

  // register read back
  always_comb begin
    prdata = '0;
    if (cfg_idx_ok) begin
      if (cfg_idx[0] == REG_BASE) begin
        prdata = CFG_W'(base_q[cfg_sec]);
      end else begin
        prdata = CFG_W'(blocks_q[cfg_sec]);
      end
    end
  end

  assign pready = 1'b1;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      wptr_q    <= '0;
      wrap_q    <= 1'b0;
      start_q   <= '0;
      bit_q     <= '0;
      rd_vld_q  <= 1'b0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
      for (int s = 0; s < SECTIONS; s++) begin
        base_q[s]   <= '0;
        blocks_q[s] <= '0;
        free_q[s]   <= '0;
        cursor_q[s] <= '0;
      end
      for (int w = 0; w < NWORDS; w++) begin
        word_vld_q[w] <= 1'b0;
      end
    end else begin
      // valid flag of the word being read
      if (ram_re) begin
        rd_vld_q <= word_vld_q[ram_raddr];
      end
      if (ram_we) begin
        word_vld_q[ram_waddr] <= 1'b1;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sec_q <= '0;
          end
        end
        ST_ALLOC_SEL: begin
          if (sec_usable) begin
            start_q <= alloc_start;
            wptr_q  <= alloc_start[IDX_W-1:WB];
            wrap_q  <= 1'b0;
          end else if (!last_sec) begin
            sec_q <= sec_q + SEC_W'(1);
          end
        end
        ST_SCAN: begin
          if (srch_found) begin
            cursor_q[sec_q] <= BLK_W'({1'b0, found_idx} + (IDX_W + 1)'(1));
            if (cur_free != '0) begin
              free_q[sec_q] <= cur_free - BLK_W'(1);
            end
            if (total_q != '0) begin
              total_q <= total_q - TOTAL_W'(1);
            end
          end else if (scan_next) begin
            wptr_q <= wptr_q + WPW'(1);
          end else if (scan_wrap) begin
            wptr_q <= '0;
            wrap_q <= 1'b1;
          end else if (sec_fail && !last_sec) begin
            sec_q <= sec_q + SEC_W'(1);
          end
        end
        ST_FREE_SEL: begin
          if (free_hit) begin
            wptr_q <= free_off[IDX_W-1:WB];
            bit_q  <= free_off[WB-1:0];
          end else if (!last_sec) begin
            sec_q <= sec_q + SEC_W'(1);
          end
        end
        ST_FREE_WR: begin
          // counts rise even on a double free, saturating
          if (cur_free != '1) begin
            free_q[sec_q] <= cur_free + BLK_W'(1);
          end
          if (total_q != '1) begin
            total_q <= total_q + TOTAL_W'(1);
          end
        end
        default: begin
        end
      endcase

      // output valid
      if (resp_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // register writes; a block count write empties its section
      if (cfg_we && cfg_idx_ok) begin
        if (cfg_idx[0] == REG_BASE) begin
          base_q[cfg_sec] <= pwdata[FRAME_W-1:0];
        end else begin
          blocks_q[cfg_sec] <= cfg_blocks;
          free_q[cfg_sec]   <= cfg_blocks;
          cursor_q[cfg_sec] <= '0;
          total_q           <= cfg_total;
          for (int s = 0; s < SECTIONS; s++) begin
            for (int w = 0; w < WPS; w++) begin
              if (SEC_W'(s) == cfg_sec) begin
                word_vld_q[s * WPS + w] <= 1'b0;
              end
            end
          end
        end
      end
    end
  end

  // item payload and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q      <= s_axis_tdata[FRAME_W-1:0];
      res_grant_q  <= '0;
      res_status_q <= (s_axis_tuser[0] == MODE_FREE) ? STAT_NOT_FOUND : STAT_NO_FREE;
    end
    if ((state_q == ST_SCAN) && srch_found) begin
      res_status_q <= STAT_OK;
      res_grant_q  <= cur_base + FRAME_W'(found_idx);
    end
    if ((state_q == ST_FREE_SEL) && free_hit) begin
      res_status_q <= STAT_OK;
    end
    if (resp_load) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
      out_total_q  <= total_q;
    end
  end

  bba_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (NWORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {7'b0, out_total_q, out_grant_q};

endmodule
